@@ design/wspr_pkg.sv @@
// Shared types and constants for the two-wheel PI speed regulator.
// Used by wspr_ser_mul and wheel_speed_pi_with_ramp_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wspr_pkg;

	// register indexes on the configuration port (byte address / 4)
	localparam logic [2:0] REG_KP        = 3'd0;
	localparam logic [2:0] REG_KI        = 3'd1;
	localparam logic [2:0] REG_INTEG_MAX = 3'd2;
	localparam logic [2:0] REG_INTEG_MIN = 3'd3;
	localparam logic [2:0] REG_OUT_MAX   = 3'd4;
	localparam logic [2:0] REG_OUT_MIN   = 3'd5;
	localparam logic [2:0] REG_RAMP_STEP = 3'd6;

	// register reset values
	localparam logic        [11:0] KP_RST        = 12'd256;
	localparam logic        [11:0] KI_RST        = 12'd26;
	localparam logic        [9:0]  INTEG_MAX_RST = 10'd400;
	localparam logic signed [10:0] INTEG_MIN_RST = -11'sd400;
	localparam logic        [8:0]  OUT_MAX_RST   = 9'd400;
	localparam logic signed [9:0]  OUT_MIN_RST   = -10'sd400;
	localparam logic        [5:0]  RAMP_STEP_RST = 6'd5;

	// setpoint saturation
	localparam logic signed [11:0] SP_SAT_HI = 12'sd1023;
	localparam logic signed [11:0] SP_SAT_LO = -12'sd1024;

	// speed to duty mapping
	localparam logic [9:0] DEAD_BAND = 10'd10;
	localparam logic [9:0] SPEED_SAT = 10'd400;
	localparam logic [9:0] DUTY_BASE = 10'd450;
	localparam logic [8:0] DUTY_STOP = 9'd500;
	localparam logic [8:0] DUTY_SAT  = 9'(DUTY_BASE - SPEED_SAT);

	// bit-serial multiplier: unsigned magnitude times gain
	localparam int MUL_A_W   = 15;
	localparam int MUL_B_W   = 12;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W);

	// magnitude of the proportional term, taken from the first product
	localparam int UP_LSB = 8;
	localparam int UP_W   = 15;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

`default_nettype wire

@@ design/wspr_ser_mul.sv @@
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// Depends on wspr_pkg for operand widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module wspr_ser_mul (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [wspr_pkg::MUL_A_W-1:0] a,
	input  wire logic [wspr_pkg::MUL_B_W-1:0] b,
	output wspr_pkg::mul_stat_t                stat,
	output logic      [wspr_pkg::MUL_P_W-1:0] prod
);

	logic [wspr_pkg::MUL_A_W-1:0]   a_q;
	logic [wspr_pkg::MUL_P_W-1:0]   p_q;
	logic [wspr_pkg::MUL_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [wspr_pkg::MUL_A_W:0]     sum;

	assign sum = {1'b0, p_q[wspr_pkg::MUL_P_W-1:wspr_pkg::MUL_B_W]}
		+ (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == wspr_pkg::MUL_CNT_W'(wspr_pkg::MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q <= a;
			p_q <= {{wspr_pkg::MUL_A_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[wspr_pkg::MUL_B_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = p_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("multiplier done while still busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("multiplier done without a run");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q <= wspr_pkg::MUL_CNT_W'(wspr_pkg::MUL_B_W - 1)))
		else $error("multiplier bit counter out of range");

endmodule

`default_nettype wire

@@ design/wheel_speed_pi_with_ramp_core.sv @@
// Top level of the two-wheel PI speed regulator with setpoint ramp.
// Depends on wspr_pkg and wspr_ser_mul.
`timescale 1ns / 1ps
`default_nettype none

// One item is taken at a time. A ramp tick passes from the input register through
// the ramp state into the output register. In a control tick the shared bit-serial
// multiplier forms kp * |err| and then ki * |up|, one gain bit per cycle, followed by
// the integral clamp, truncation, output clamp and duty mapping states. The result
// sits in an output register, so the next item is taken while a result waits.
// Setpoints and integrals of both wheels reset to zero at once.

module wheel_speed_pi_with_ramp_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// stream in
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // target_speed[9:0], measured_speed[20:10]
	input  wire logic [1:0]  s_tuser,   // req_type[0], wheel_sel[1]
	// stream out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // drive_speed[9:0], reverse[10], duty[19:11],
	                                    // ramped_speed[30:20]
	output logic      [1:0]  m_tuser,   // out_wheel[0], drive_valid[1]
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_RAMP  = 9'b000000010,
		ST_ERR   = 9'b000000100,
		ST_MUL1  = 9'b000001000,
		ST_MUL2  = 9'b000010000,
		ST_CLAMP = 9'b000100000,
		ST_TRUNC = 9'b001000000,
		ST_SUM   = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	state_t state_q, state_nxt;

	// configuration registers
	logic        [11:0] kp_q, ki_q;
	logic        [9:0]  integ_max_q;
	logic signed [10:0] integ_min_q;
	logic        [8:0]  out_max_q;
	logic signed [9:0]  out_min_q;
	logic        [5:0]  ramp_step_q;
	logic               cfg_we;

	// per-wheel state
	logic signed [10:0] sp_q    [2];
	logic signed [19:0] integ_q [2];

	// latched item
	logic               in_req_q, in_wheel_q;
	logic signed [9:0]  in_tgt_q;
	logic signed [10:0] in_meas_q;
	logic               in_xfer;

	// working registers
	logic               err_neg_q;
	logic signed [15:0] up_s_q;
	logic signed [28:0] acc_q;
	logic signed [19:0] integ_c_q;
	logic signed [11:0] tq_q;
	logic signed [9:0]  v_q;

	// output register
	logic               out_valid_q;
	logic               out_wheel_q, out_dv_q, out_rev_q;
	logic signed [9:0]  out_speed_q;
	logic        [8:0]  out_duty_q;
	logic signed [10:0] out_ramped_q;
	logic               slot_free, out_we;

	// multiplier
	logic                          mul_start;
	logic [wspr_pkg::MUL_A_W-1:0] mul_a;
	logic [wspr_pkg::MUL_B_W-1:0] mul_b;
	wspr_pkg::mul_stat_t           mul_stat;
	logic [wspr_pkg::MUL_P_W-1:0] mul_prod;

	// datapath nets
	logic signed [10:0] sp_cur, tgt_ext, sp_new;
	logic signed [11:0] ramp_sum, err;
	logic        [11:0] err_mag;
	logic [wspr_pkg::UP_W-1:0] up_mag;
	logic signed [28:0] acc_new, integ_hi, integ_lo;
	logic signed [28:0] integ_c;
	logic signed [19:0] tq_sum;
	logic signed [16:0] pi_sum, out_hi, out_lo;
	logic signed [9:0]  v_fix;
	logic        [9:0]  v_mag;
	logic        [8:0]  duty;

	wspr_ser_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mul_stat),
		.prod   (mul_prod)
	);

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= wspr_pkg::KP_RST;
			ki_q        <= wspr_pkg::KI_RST;
			integ_max_q <= wspr_pkg::INTEG_MAX_RST;
			integ_min_q <= wspr_pkg::INTEG_MIN_RST;
			out_max_q   <= wspr_pkg::OUT_MAX_RST;
			out_min_q   <= wspr_pkg::OUT_MIN_RST;
			ramp_step_q <= wspr_pkg::RAMP_STEP_RST;
		end else if (cfg_we) begin
			case (paddr[4:2])
				wspr_pkg::REG_KP:        kp_q        <= pwdata[11:0];
				wspr_pkg::REG_KI:        ki_q        <= pwdata[11:0];
				wspr_pkg::REG_INTEG_MAX: integ_max_q <= pwdata[9:0];
				wspr_pkg::REG_INTEG_MIN: integ_min_q <= pwdata[10:0];
				wspr_pkg::REG_OUT_MAX:   out_max_q   <= pwdata[8:0];
				wspr_pkg::REG_OUT_MIN:   out_min_q   <= pwdata[9:0];
				wspr_pkg::REG_RAMP_STEP: ramp_step_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			wspr_pkg::REG_KP:        prdata = {20'b0, kp_q};
			wspr_pkg::REG_KI:        prdata = {20'b0, ki_q};
			wspr_pkg::REG_INTEG_MAX: prdata = {22'b0, integ_max_q};
			wspr_pkg::REG_INTEG_MIN: prdata = {{21{integ_min_q[10]}}, integ_min_q};
			wspr_pkg::REG_OUT_MAX:   prdata = {23'b0, out_max_q};
			wspr_pkg::REG_OUT_MIN:   prdata = {{22{out_min_q[9]}}, out_min_q};
			wspr_pkg::REG_RAMP_STEP: prdata = {26'b0, ramp_step_q};
			default:                 prdata = 32'b0;
		endcase
	end

	// input transfer
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			in_req_q   <= s_tuser[0];
			in_wheel_q <= s_tuser[1];
			in_tgt_q   <= s_tdata[9:0];
			in_meas_q  <= s_tdata[20:10];
		end
	end

	// ramp step
	assign sp_cur  = sp_q[in_wheel_q];
	assign tgt_ext = {in_tgt_q[9], in_tgt_q};

	always_comb begin
		if (tgt_ext > sp_cur) begin
			ramp_sum = {sp_cur[10], sp_cur} + $signed({6'b0, ramp_step_q});
		end else if (tgt_ext < sp_cur) begin
			ramp_sum = {sp_cur[10], sp_cur} - $signed({6'b0, ramp_step_q});
		end else begin
			ramp_sum = {sp_cur[10], sp_cur};
		end
		if (ramp_sum > wspr_pkg::SP_SAT_HI) begin
			sp_new = wspr_pkg::SP_SAT_HI[10:0];
		end else if (ramp_sum < wspr_pkg::SP_SAT_LO) begin
			sp_new = wspr_pkg::SP_SAT_LO[10:0];
		end else begin
			sp_new = ramp_sum[10:0];
		end
	end

	// error and multiplier operands
	assign err     = {sp_cur[10], sp_cur} - {in_meas_q[10], in_meas_q};
	assign err_mag = err[11] ? 12'(-err) : err;
	assign up_mag  = mul_prod[wspr_pkg::UP_LSB +: wspr_pkg::UP_W];

	always_comb begin
		mul_start = 1'b0;
		mul_a     = wspr_pkg::MUL_A_W'(err_mag);
		mul_b     = kp_q;
		if (state_q == ST_ERR) begin
			mul_start = 1'b1;
		end else if (state_q == ST_MUL1 && mul_stat.done) begin
			mul_start = 1'b1;
			mul_a     = up_mag;
			mul_b     = ki_q;
		end
	end

	// integral update and clamp
	assign acc_new = err_neg_q
		? $signed({{9{integ_q[in_wheel_q][19]}}, integ_q[in_wheel_q]})
			- $signed({2'b0, mul_prod})
		: $signed({{9{integ_q[in_wheel_q][19]}}, integ_q[in_wheel_q]})
			+ $signed({2'b0, mul_prod});
	assign integ_hi = $signed({11'b0, integ_max_q, 8'b0});
	assign integ_lo = $signed({{10{integ_min_q[10]}}, integ_min_q, 8'b0});

	always_comb begin
		if (acc_q > integ_hi) begin
			integ_c = integ_hi;
		end else if (acc_q < integ_lo) begin
			integ_c = integ_lo;
		end else begin
			integ_c = acc_q;
		end
	end

	// truncate toward zero, then output clamp
	assign tq_sum = integ_c_q[19] ? integ_c_q + 20'sd255 : integ_c_q;
	assign pi_sum = {up_s_q[15], up_s_q} + {{5{tq_q[11]}}, tq_q};
	assign out_hi = $signed({8'b0, out_max_q});
	assign out_lo = {{7{out_min_q[9]}}, out_min_q};

	// sign agreement and duty mapping
	always_comb begin
		v_fix = v_q;
		if (!sp_cur[10] && v_q[9]) begin
			v_fix = 10'sd1;
		end else if (sp_cur[10] && !v_q[9] && v_q != 10'sd0) begin
			v_fix = -10'sd1;
		end
		v_mag = v_fix[9] ? 10'(-v_fix) : v_fix;
		if (v_mag < wspr_pkg::DEAD_BAND) begin
			duty = wspr_pkg::DUTY_STOP;
		end else if (v_mag > wspr_pkg::SPEED_SAT) begin
			duty = wspr_pkg::DUTY_SAT;
		end else begin
			duty = 9'(wspr_pkg::DUTY_BASE - v_mag);
		end
	end

	// sequencer
	assign slot_free = !out_valid_q || m_tready;
	assign out_we    = (state_q == ST_RAMP || state_q == ST_FIN) && slot_free;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (in_xfer) state_nxt = s_tuser[0] ? ST_ERR : ST_RAMP;
			ST_RAMP:  if (slot_free) state_nxt = ST_IDLE;
			ST_ERR:   state_nxt = ST_MUL1;
			ST_MUL1:  if (mul_stat.done) state_nxt = ST_MUL2;
			ST_MUL2:  if (mul_stat.done) state_nxt = ST_CLAMP;
			ST_CLAMP: state_nxt = ST_TRUNC;
			ST_TRUNC: state_nxt = ST_SUM;
			ST_SUM:   state_nxt = ST_FIN;
			ST_FIN:   if (slot_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sp_q[0]    <= '0;
			sp_q[1]    <= '0;
			integ_q[0] <= '0;
			integ_q[1] <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_RAMP && slot_free) begin
				sp_q[in_wheel_q] <= sp_new;
			end
			if (state_q == ST_CLAMP) begin
				integ_q[in_wheel_q] <= integ_c[19:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_ERR: err_neg_q <= err[11];
			ST_MUL1: begin
				if (mul_stat.done) begin
					up_s_q <= err_neg_q ? -$signed({1'b0, up_mag}) : $signed({1'b0, up_mag});
				end
			end
			ST_MUL2:  if (mul_stat.done) acc_q <= acc_new;
			ST_CLAMP: integ_c_q <= integ_c[19:0];
			ST_TRUNC: tq_q <= tq_sum[19:8];
			ST_SUM: begin
				if (pi_sum > out_hi) begin
					v_q <= out_hi[9:0];
				end else if (pi_sum < out_lo) begin
					v_q <= out_lo[9:0];
				end else begin
					v_q <= pi_sum[9:0];
				end
			end
			default: ;
		endcase
	end

	// output register: hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_we) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_we) begin
			out_wheel_q <= in_wheel_q;
			if (state_q == ST_FIN) begin
				out_dv_q     <= 1'b1;
				out_speed_q  <= v_fix;
				out_rev_q    <= v_fix[9];
				out_duty_q   <= duty;
				out_ramped_q <= sp_cur;
			end else begin
				out_dv_q     <= 1'b0;
				out_speed_q  <= '0;
				out_rev_q    <= 1'b0;
				out_duty_q   <= wspr_pkg::DUTY_STOP;
				out_ramped_q <= sp_new;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_ramped_q, out_duty_q, out_rev_q, out_speed_q};
	assign m_tuser  = {out_dv_q, out_wheel_q};

	a_mul_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_stat.busy)
		else $error("multiplier started while busy");

	a_integ_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRUNC) |-> (integ_c_q <= integ_hi || integ_c_q == integ_lo))
		else $error("integral outside its clamp limits");

	a_ramp_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> (m_tdata[19:11] == wspr_pkg::DUTY_STOP))
		else $error("ramp result without stop duty");

endmodule

`default_nettype wire

@@ tb/sv/wheel_speed_pi_with_ramp_core_tb.sv @@
// Self-checking bench for wheel_speed_pi_with_ramp_core: directed and random ramp and
// control ticks, checked against a scoreboard that predicts every drive result.
// Depends on wspr_pkg and the core RTL.
`timescale 1ns / 1ps

module wheel_speed_pi_with_ramp_core_tb;
	import wspr_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam bit REQ_RAMP = 1'b0;
	localparam bit REQ_CTRL = 1'b1;
	localparam bit WHEEL_L = 1'b0;
	localparam bit WHEEL_R = 1'b1;
	localparam int SP_TOP = 1023;
	localparam int SP_BOTTOM = -1024;
	localparam int DEADBAND_SPEED = 10;
	localparam int SAT_LEVEL = 400;
	localparam int DUTY_OFFSET = 450;
	localparam int DUTY_IDLE = 500;
	localparam int HOLD_CYCLES = 400;

	typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	typedef struct {
		bit req;
		bit wheel;
		int target;
		int meas;
	} tick_t;

	typedef struct packed {
		logic              wheel;
		logic              dvalid;
		logic signed [9:0] speed;
		logic              rev;
		logic [8:0]        duty;
		logic signed [10:0] ramped;
	} drive_t;

	class drive_scoreboard;
		int kp, ki, integ_max, integ_min, out_max, out_min, ramp_step;
		int setpoint[2];
		longint integral[2];
		drive_t drive_q[$];
		int mismatches, results_seen, ramp_ticks, ctrl_ticks;

		function new();
			kp = KP_RST;
			ki = KI_RST;
			integ_max = INTEG_MAX_RST;
			integ_min = INTEG_MIN_RST;
			out_max = OUT_MAX_RST;
			out_min = OUT_MIN_RST;
			ramp_step = RAMP_STEP_RST;
			setpoint[0] = 0;
			setpoint[1] = 0;
			integral[0] = 0;
			integral[1] = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_KP:        kp = int'(val[11:0]);
				REG_KI:        ki = int'(val[11:0]);
				REG_INTEG_MAX: integ_max = int'(val[9:0]);
				REG_INTEG_MIN: integ_min = int'($signed(val[10:0]));
				REG_OUT_MAX:   out_max = int'(val[8:0]);
				REG_OUT_MIN:   out_min = int'($signed(val[9:0]));
				REG_RAMP_STEP: ramp_step = int'(val[5:0]);
				default: ;
			endcase
		endfunction

		// truncate a Q.8 value toward zero
		function longint drop_q8(longint x);
			return (x < 0) ? -((-x) >>> 8) : (x >>> 8);
		endfunction

		function void note_tick(tick_t t);
			drive_t r;
			int sp, v, mag;
			longint err, up, acc, pi;
			sp = setpoint[t.wheel];
			r = '0;
			r.wheel = t.wheel;
			if (t.req == REQ_RAMP) begin
				ramp_ticks++;
				if (t.target > sp)
					sp += ramp_step;
				else if (t.target < sp)
					sp -= ramp_step;
				if (sp > SP_TOP)
					sp = SP_TOP;
				if (sp < SP_BOTTOM)
					sp = SP_BOTTOM;
				setpoint[t.wheel] = sp;
				r.duty = 9'(DUTY_IDLE);
			end else begin
				ctrl_ticks++;
				err = sp - t.meas;
				up = drop_q8(kp * err);
				acc = integral[t.wheel] + up * ki;
				if (acc > integ_max * 256)
					acc = integ_max * 256;
				else if (acc < integ_min * 256)
					acc = integ_min * 256;
				integral[t.wheel] = acc;
				pi = up + drop_q8(acc);
				if (pi > out_max)
					pi = out_max;
				else if (pi < out_min)
					pi = out_min;
				v = int'(pi);
				if (sp >= 0) begin
					if (v < 0)
						v = 1;
				end else if (v > 0) begin
					v = -1;
				end
				mag = (v < 0) ? -v : v;
				r.dvalid = 1'b1;
				r.speed = 10'(v);
				r.rev = (v < 0);
				if (mag < DEADBAND_SPEED)
					r.duty = 9'(DUTY_IDLE);
				else if (mag > SAT_LEVEL)
					r.duty = 9'(DUTY_OFFSET - SAT_LEVEL);
				else
					r.duty = 9'(DUTY_OFFSET - mag);
			end
			r.ramped = 11'(sp);
			drive_q.push_back(r);
		endfunction

		function string show(drive_t r);
			return $sformatf("wheel %0d valid %0d speed %0d rev %0d duty %0d ramped %0d",
				r.wheel, r.dvalid, r.speed, r.rev, r.duty, r.ramped);
		endfunction

		function void check_result(drive_t got);
			drive_t want;
			results_seen++;
			if (drive_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %s", show(got));
				return;
			end
			want = drive_q.pop_front();
			if (got.wheel !== want.wheel || got.dvalid !== want.dvalid ||
			    got.speed !== want.speed || got.rev !== want.rev ||
			    got.duty !== want.duty || got.ramped !== want.ramped) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on result %0d: expected %s, got %s",
						results_seen, show(want), show(got));
			end
		endfunction

		function int pending();
			return drive_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	drive_scoreboard sb;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int seg_left = 0;
	int rx_phase = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int burst_left = 1;
	int steady = 0;
	int settings = 0;

	wheel_speed_pi_with_ramp_core uut (.*);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("wheel_speed_pi_with_ramp_core_tb: errors");
		$finish;
	end

	// receiver: check each transfer, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(drive_t'({m_tuser[0], m_tuser[1], m_tdata[9:0], m_tdata[10],
					m_tdata[19:11], m_tdata[30:20]}));
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					seg_left = $urandom_range(16, 160);
				end
				seg_left--;
				rx_phase++;
				case (rx_mode)
					RX_OPEN:   m_tready <= 1'b1;
					RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= ((rx_phase % 7) < 3);
				endcase
			end
		end
	end

	function automatic tick_t tick(bit req, bit wheel, int target, int meas);
		tick_t t;
		t.req = req;
		t.wheel = wheel;
		t.target = target;
		t.meas = meas;
		return t;
	endfunction

	function automatic int rand_target();
		return int'($urandom_range(0, 1023)) - 512;
	endfunction

	function automatic int rand_meas();
		return int'($urandom_range(0, 2047)) - 1024;
	endfunction

	task automatic offer(input tick_t t);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= {t.wheel, t.req};
		s_tdata <= {3'b000, 11'(t.meas), 10'(t.target)};
		do @(posedge clk); while (!s_tready);
		sb.note_tick(t);
		if (steady > 0) begin
			steady--;
		end else begin
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	task automatic wait_settled();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input int val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic apply_setting(input int kp, ki, imax, imin, omax, omin, step);
		wait_settled();
		apb_write(REG_KP, kp);
		apb_write(REG_KI, ki);
		apb_write(REG_INTEG_MAX, imax);
		apb_write(REG_INTEG_MIN, imin);
		apb_write(REG_OUT_MAX, omax);
		apb_write(REG_OUT_MIN, omin);
		apb_write(REG_RAMP_STEP, step);
		settings++;
	endtask

	initial begin
		int w, tgt, meas, nramp, nctrl, k, phase, count;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: dead band, overshoot hunting, saturation, sign forcing
		offer(tick(REQ_CTRL, WHEEL_L, 0, 0));
		offer(tick(REQ_RAMP, WHEEL_L, 7, 0));
		offer(tick(REQ_RAMP, WHEEL_L, 7, 0));
		offer(tick(REQ_RAMP, WHEEL_L, 7, 0));
		offer(tick(REQ_RAMP, WHEEL_L, 5, 0));
		offer(tick(REQ_CTRL, WHEEL_L, 0, -1024));
		offer(tick(REQ_CTRL, WHEEL_L, 0, 1023));
		offer(tick(REQ_RAMP, WHEEL_R, -512, 0));
		offer(tick(REQ_CTRL, WHEEL_R, 0, 200));
		offer(tick(REQ_CTRL, WHEEL_R, 0, -300));
		offer(tick(REQ_RAMP, WHEEL_R, 511, 0));
		offer(tick(REQ_CTRL, WHEEL_R, 0, -20));

		// largest gains and limits
		apply_setting(4095, 4095, 1023, -1024, 511, -512, 63);
		offer(tick(REQ_RAMP, WHEEL_L, 511, 0));
		offer(tick(REQ_RAMP, WHEEL_L, 511, 0));
		offer(tick(REQ_CTRL, WHEEL_L, 0, -1024));
		offer(tick(REQ_CTRL, WHEEL_L, 0, 1023));
		offer(tick(REQ_RAMP, WHEEL_R, -512, 0));
		offer(tick(REQ_CTRL, WHEEL_R, 0, 1023));

		// all limits at zero
		apply_setting(0, 0, 0, 0, 0, 0, 1);
		offer(tick(REQ_RAMP, WHEEL_L, -512, 0));
		offer(tick(REQ_CTRL, WHEEL_L, 0, 0));
		offer(tick(REQ_CTRL, WHEEL_R, 0, 0));

		// lower clamps above upper clamps; write to an unmapped register
		apply_setting(256, 256, 50, 100, 10, 20, 1);
		apb_write(REG_UNUSED, -1);
		offer(tick(REQ_CTRL, WHEEL_L, 0, 0));
		offer(tick(REQ_CTRL, WHEEL_R, 0, -1000));

		for (phase = 0; phase < 8; phase++) begin
			if (phase == 0)
				apply_setting(KP_RST, KI_RST, INTEG_MAX_RST, INTEG_MIN_RST,
					OUT_MAX_RST, OUT_MIN_RST, RAMP_STEP_RST);
			else if (phase == 4)
				apply_setting(4095, 4095, 1023, -1024, 511, -512, 63);
			else
				apply_setting(
					$urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(64, 768),
					$urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 128),
					$urandom_range(0, 1023), -int'($urandom_range(0, 1024)),
					$urandom_range(0, 511), -int'($urandom_range(0, 512)),
					$urandom_range(1, 63));
			if (phase == 2) begin
				hold_token <= hold_token + 1;
				steady = 30;
			end
			count = 0;
			while (count < 180) begin
				w = $urandom_range(0, 1);
				if ($urandom_range(0, 6) == 0) begin
					offer(tick($urandom_range(0, 1), w, rand_target(), rand_meas()));
					count++;
				end else begin
					tgt = rand_target();
					nramp = $urandom_range(1, 6);
					nctrl = $urandom_range(2, 10);
					for (k = 0; k < nramp; k++)
						offer(tick(REQ_RAMP, w, tgt, rand_meas()));
					for (k = 0; k < nctrl; k++) begin
						meas = sb.setpoint[w] + int'($urandom_range(0, 80)) - 40;
						offer(tick(REQ_CTRL, w, rand_target(), meas));
					end
					count += nramp + nctrl;
				end
			end
		end

		wait_settled();
		repeat (40) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0d expected results never arrived", sb.pending());
			sb.mismatches += sb.pending();
		end
		$display("checked %0d results: %0d ramp and %0d control ticks over %0d settings",
			sb.results_seen, sb.ramp_ticks, sb.ctrl_ticks, settings);
		$display("with random stalls on both sides, one long output hold and crossed clamps");
		if (sb.mismatches == 0)
			$display("wheel_speed_pi_with_ramp_core_tb: clean");
		else
			$display("wheel_speed_pi_with_ramp_core_tb: errors");
		$finish;
	end

endmodule
